@@ src/lst_pkg.sv @@
`default_nettype none

package lst_pkg;

	// field widths
	localparam int TEMP_W  = 11;
	localparam int DOY_W   = 9;
	localparam int PREC_W  = 12;
	localparam int LAI_W   = 12;
	localparam int LOOK_W  = 5;
	localparam int PSUM_W  = 16;
	localparam int DIY_W   = 9;
	localparam int PHASE_W = 2;

	// apb
	localparam int ADDR_W = 5;
	localparam int DATA_W = 32;

	// window and ramp sizing
	localparam int MAX_WINDOW_DAYS = 32;
	localparam int RAMP_DAYS       = 30;
	localparam int FILL_W          = $clog2(MAX_WINDOW_DAYS + 1);
	localparam int TREE_LVL        = $clog2(MAX_WINDOW_DAYS);
	localparam int TREE_N          = 2 ** TREE_LVL;
	localparam int RATIO_W         = $clog2(RAMP_DAYS + 1);

	// calendar
	localparam int DROOP_FROM_DAY = 182;
	localparam int NORTH_START    = 1;
	localparam int SOUTH_START    = 183;

	// divide by RAMP_DAYS as multiply by rounded-up reciprocal, exact for ratio*diff
	localparam int PROD_W      = RATIO_W + LAI_W;
	localparam int RECIP_SHIFT = 22;
	localparam int RECIP_MULT  = (2 ** RECIP_SHIFT + RAMP_DAYS - 1) / RAMP_DAYS;
	localparam int RECIP_W     = $clog2(RECIP_MULT + 1);

	// register reset values
	localparam logic [LAI_W-1:0]         LAI_MIN_RST     = 12'd0;
	localparam logic [LAI_W-1:0]         LAI_MAX_RST     = 12'd1024;
	localparam logic [LOOK_W-1:0]        WINDOW_DAYS_RST = 5'd10;
	localparam logic [PSUM_W-1:0]        PRECIP_THR_RST  = 16'd640;
	localparam logic signed [TEMP_W-1:0] TEMP_THR_RST    = 11'sd128;

	// window sentinels for entries outside the span
	localparam logic signed [TEMP_W-1:0] TEMP_HI = {1'b0, {(TEMP_W-1){1'b1}}};
	localparam logic signed [TEMP_W-1:0] TEMP_LO = {1'b1, {(TEMP_W-1){1'b0}}};

	typedef enum logic [2:0] {
		REG_LAI_MIN     = 3'd0,
		REG_LAI_MAX     = 3'd1,
		REG_WINDOW_DAYS = 3'd2,
		REG_SOUTHERN    = 3'd3,
		REG_PRECIP_THR  = 3'd4,
		REG_TEMP_THR    = 3'd5
	} reg_idx_t;

	typedef enum logic [PHASE_W-1:0] {
		PH_HELD  = 2'd0,
		PH_GROW  = 2'd1,
		PH_DROOP = 2'd2
	} phase_t;

	typedef struct packed {
		logic [LAI_W-1:0]         lai_min;
		logic [LAI_W-1:0]         lai_max;
		logic [LOOK_W-1:0]        window_days;
		logic                     southern_hemisphere;
		logic [PSUM_W-1:0]        precip_threshold;
		logic signed [TEMP_W-1:0] temp_threshold;
	} cfg_t;

	typedef struct packed {
		logic signed [TEMP_W-1:0] tmin;
		logic signed [TEMP_W-1:0] tmax;
	} win_stat_t;

endpackage

`default_nettype wire

@@ src/lst_if.sv @@
`default_nettype none

interface lst_day_if;
	logic                             valid;
	logic                             ready;
	logic                             series_start;
	logic [lst_pkg::DOY_W-1:0]        day_of_year;
	logic signed [lst_pkg::TEMP_W-1:0] temperature;
	logic [lst_pkg::PREC_W-1:0]       precipitation;

	modport source (output valid, series_start, day_of_year, temperature, precipitation,
		input ready);
	modport sink (input valid, series_start, day_of_year, temperature, precipitation,
		output ready);
endinterface

interface lst_lai_if;
	logic                              valid;
	logic                              ready;
	logic [lst_pkg::LAI_W-1:0]         leaf_area_index;
	logic [lst_pkg::RATIO_W-1:0]       leaf_ratio;
	logic [lst_pkg::PHASE_W-1:0]       season_phase;

	modport source (output valid, leaf_area_index, leaf_ratio, season_phase, input ready);
	modport sink (input valid, leaf_area_index, leaf_ratio, season_phase, output ready);
endinterface

`default_nettype wire

@@ src/lst_cfg.sv @@
`default_nettype none

module lst_cfg (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        psel,
	input  wire logic                        penable,
	input  wire logic                        pwrite,
	input  wire logic [lst_pkg::ADDR_W-1:0]  paddr,
	input  wire logic [lst_pkg::DATA_W-1:0]  pwdata,
	output logic      [lst_pkg::DATA_W-1:0]  prdata,
	output logic                             pready,
	output lst_pkg::cfg_t                    cfg
);
	import lst_pkg::*;

	cfg_t     cfg_q;
	logic     wr_en;
	reg_idx_t idx;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite;
	assign idx    = reg_idx_t'(paddr[ADDR_W-1:2]);
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.lai_min             <= LAI_MIN_RST;
			cfg_q.lai_max             <= LAI_MAX_RST;
			cfg_q.window_days         <= WINDOW_DAYS_RST;
			cfg_q.southern_hemisphere <= 1'b0;
			cfg_q.precip_threshold    <= PRECIP_THR_RST;
			cfg_q.temp_threshold      <= TEMP_THR_RST;
		end else if (wr_en) begin
			case (idx)
				REG_LAI_MIN:     cfg_q.lai_min             <= pwdata[LAI_W-1:0];
				REG_LAI_MAX:     cfg_q.lai_max             <= pwdata[LAI_W-1:0];
				REG_WINDOW_DAYS: cfg_q.window_days         <= pwdata[LOOK_W-1:0];
				REG_SOUTHERN:    cfg_q.southern_hemisphere <= pwdata[0];
				REG_PRECIP_THR:  cfg_q.precip_threshold    <= pwdata[PSUM_W-1:0];
				REG_TEMP_THR:    cfg_q.temp_threshold      <= pwdata[TEMP_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		prdata = '0;
		case (idx)
			REG_LAI_MIN:     prdata = DATA_W'(cfg_q.lai_min);
			REG_LAI_MAX:     prdata = DATA_W'(cfg_q.lai_max);
			REG_WINDOW_DAYS: prdata = DATA_W'(cfg_q.window_days);
			REG_SOUTHERN:    prdata = DATA_W'(cfg_q.southern_hemisphere);
			REG_PRECIP_THR:  prdata = DATA_W'(cfg_q.precip_threshold);
			REG_TEMP_THR:    prdata = DATA_W'($unsigned(cfg_q.temp_threshold));
			default:         prdata = '0;
		endcase
	end

endmodule

`default_nettype wire

@@ src/lst_window.sv @@
`default_nettype none

module lst_window (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              take,
	input  wire logic                              series_start,
	input  wire logic signed [lst_pkg::TEMP_W-1:0] temperature,
	input  wire logic [lst_pkg::LOOK_W-1:0]        window_days,
	output lst_pkg::win_stat_t                     stat
);
	import lst_pkg::*;

	logic signed [TEMP_W-1:0] taps_q [MAX_WINDOW_DAYS];
	logic signed [TEMP_W-1:0] taps_n [MAX_WINDOW_DAYS];
	logic [FILL_W-1:0]        fill_q;
	logic [FILL_W-1:0]        fill_base;
	logic [FILL_W-1:0]        fill_n;
	logic [FILL_W-1:0]        look;
	logic [FILL_W-1:0]        span;
	logic signed [TEMP_W-1:0] lo [TREE_LVL+1][TREE_N];
	logic signed [TEMP_W-1:0] hi [TREE_LVL+1][TREE_N];

	always_comb begin
		taps_n[0] = temperature;
		for (int i = 1; i < MAX_WINDOW_DAYS; i++) begin
			taps_n[i] = taps_q[i-1];
		end
	end

	// series start empties the window before today enters
	assign fill_base = series_start ? '0 : fill_q;
	assign fill_n    = (fill_base == FILL_W'(MAX_WINDOW_DAYS)) ? fill_base
		: fill_base + 1'b1;

	always_comb begin
		if (int'(window_days) > MAX_WINDOW_DAYS - 1) begin
			look = FILL_W'(MAX_WINDOW_DAYS - 1);
		end else begin
			look = FILL_W'(window_days);
		end
		span = (look + 1'b1 > fill_n) ? fill_n : look + 1'b1;
	end

	// min/max tree, entries past the span read as neutral sentinels
	always_comb begin
		lo = '{default: '0};
		hi = '{default: '0};
		for (int i = 0; i < TREE_N; i++) begin
			if (i < MAX_WINDOW_DAYS && i < int'(span)) begin
				lo[0][i] = taps_n[i];
				hi[0][i] = taps_n[i];
			end else begin
				lo[0][i] = TEMP_HI;
				hi[0][i] = TEMP_LO;
			end
		end
		for (int l = 1; l <= TREE_LVL; l++) begin
			for (int j = 0; j < (TREE_N >> l); j++) begin
				lo[l][j] = (lo[l-1][2*j+1] < lo[l-1][2*j]) ? lo[l-1][2*j+1] : lo[l-1][2*j];
				hi[l][j] = (hi[l-1][2*j+1] > hi[l-1][2*j]) ? hi[l-1][2*j+1] : hi[l-1][2*j];
			end
		end
	end

	assign stat.tmin = lo[TREE_LVL][0];
	assign stat.tmax = hi[TREE_LVL][0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
		end else if (take) begin
			fill_q <= fill_n;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			taps_q <= taps_n;
		end
	end

endmodule

`default_nettype wire

@@ src/lst_season.sv @@
`default_nettype none

module lst_season (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         take,
	input  wire logic                         series_start,
	input  wire logic [lst_pkg::DOY_W-1:0]    day_of_year,
	input  wire logic [lst_pkg::PREC_W-1:0]   precipitation,
	input  wire lst_pkg::win_stat_t           stat,
	input  wire lst_pkg::cfg_t                cfg,
	output logic      [lst_pkg::RATIO_W-1:0]  ratio,
	output lst_pkg::phase_t                   phase
);
	import lst_pkg::*;

	logic               ya_q, grown_q, drooped_q;
	logic [DIY_W-1:0]   diy_q;
	logic [PSUM_W-1:0]  psum_q;
	logic [RATIO_W-1:0] gc_q, dc_q, held_q;

	logic               ya, grown, drooped;
	logic [DIY_W-1:0]   diy;
	logic [PSUM_W-1:0]  psum;
	logic [PSUM_W:0]    psum_wide;
	logic [RATIO_W-1:0] gc, dc;
	logic [RATIO_W:0]   gc_inc;
	logic               year_start, grow_now, droop_now;

	assign year_start = day_of_year == (cfg.southern_hemisphere ? DOY_W'(SOUTH_START)
		: DOY_W'(NORTH_START));

	always_comb begin
		ya        = series_start ? 1'b0 : ya_q;
		grown     = series_start ? 1'b0 : grown_q;
		drooped   = series_start ? 1'b0 : drooped_q;
		diy       = series_start ? '0 : diy_q;
		psum      = series_start ? '0 : psum_q;
		gc        = series_start ? '0 : gc_q;
		dc        = series_start ? '0 : dc_q;
		grow_now  = 1'b0;
		droop_now = 1'b0;
		psum_wide = '0;
		gc_inc    = '0;

		if (year_start) begin
			ya      = 1'b1;
			diy     = '0;
			psum    = '0;
			grown   = 1'b0;
			drooped = 1'b0;
			gc      = '0;
			dc      = '0;
		end else if (ya && diy != '1) begin
			diy = diy + 1'b1;
		end

		if (ya) begin
			psum_wide = {1'b0, psum} + (PSUM_W+1)'(precipitation);
			psum      = psum_wide[PSUM_W] ? '1 : psum_wide[PSUM_W-1:0];
			if (grown && gc < RATIO_W'(RAMP_DAYS)) gc = gc + 1'b1;
			if (drooped && dc < RATIO_W'(RAMP_DAYS)) dc = dc + 1'b1;
			droop_now = !drooped && diy >= DIY_W'(DROOP_FROM_DAY)
				&& $signed(stat.tmax) < $signed(cfg.temp_threshold);
			grow_now  = !grown && !drooped && psum > cfg.precip_threshold
				&& $signed(stat.tmin) > $signed(cfg.temp_threshold);
			if (droop_now) begin
				drooped = 1'b1;
				dc      = '0;
			end
			if (grow_now) begin
				grown = 1'b1;
				gc    = '0;
			end
		end

		// droop wins over growth
		if (ya && drooped) begin
			ratio = RATIO_W'(RAMP_DAYS) - ((dc < RATIO_W'(RAMP_DAYS)) ? dc : RATIO_W'(RAMP_DAYS));
			phase = PH_DROOP;
		end else if (ya && grown) begin
			gc_inc = {1'b0, gc} + 1'b1;
			ratio  = (gc_inc > (RATIO_W+1)'(RAMP_DAYS)) ? RATIO_W'(RAMP_DAYS)
				: gc_inc[RATIO_W-1:0];
			phase  = PH_GROW;
		end else begin
			ratio = series_start ? '0 : held_q;
			phase = PH_HELD;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ya_q      <= 1'b0;
			grown_q   <= 1'b0;
			drooped_q <= 1'b0;
			diy_q     <= '0;
			psum_q    <= '0;
			gc_q      <= '0;
			dc_q      <= '0;
			held_q    <= '0;
		end else if (take) begin
			ya_q      <= ya;
			grown_q   <= grown;
			drooped_q <= drooped;
			diy_q     <= diy;
			psum_q    <= psum;
			gc_q      <= gc;
			dc_q      <= dc;
			held_q    <= ratio;
		end
	end

endmodule

`default_nettype wire

@@ src/lst_scale.sv @@
`default_nettype none

module lst_scale (
	input  wire logic                         clk,
	input  wire logic                         load_s2,
	input  wire logic                         load_s3,
	input  wire logic [lst_pkg::RATIO_W-1:0]  ratio,
	input  wire lst_pkg::phase_t              phase,
	input  wire lst_pkg::cfg_t                cfg,
	output logic      [lst_pkg::LAI_W-1:0]    leaf_area_index,
	output logic      [lst_pkg::RATIO_W-1:0]  leaf_ratio,
	output lst_pkg::phase_t                   season_phase
);
	import lst_pkg::*;

	logic                        up;
	logic [LAI_W-1:0]            diff;
	logic [PROD_W-1:0]           prod_s2;
	logic [RATIO_W-1:0]          ratio_s2, ratio_s3;
	phase_t                      phase_s2, phase_s3;
	logic [PROD_W+RECIP_W-1:0]   recip_prod;
	logic [LAI_W-1:0]            quot;
	logic [LAI_W-1:0]            lai_s3;

	// reversed limits move from lai_min down toward lai_max
	assign up   = cfg.lai_max >= cfg.lai_min;
	assign diff = up ? cfg.lai_max - cfg.lai_min : cfg.lai_min - cfg.lai_max;

	assign recip_prod = (PROD_W+RECIP_W)'(prod_s2) * (PROD_W+RECIP_W)'(RECIP_MULT);
	assign quot       = recip_prod[RECIP_SHIFT +: LAI_W];

	always_ff @(posedge clk) begin
		if (load_s2) begin
			prod_s2  <= PROD_W'(ratio) * PROD_W'(diff);
			ratio_s2 <= ratio;
			phase_s2 <= phase;
		end
		if (load_s3) begin
			lai_s3   <= up ? cfg.lai_min + quot : cfg.lai_min - quot;
			ratio_s3 <= ratio_s2;
			phase_s3 <= phase_s2;
		end
	end

	assign leaf_area_index = lai_s3;
	assign leaf_ratio      = ratio_s3;
	assign season_phase    = phase_s3;

endmodule

`default_nettype wire

@@ src/leaf_area_season_tracker.sv @@
// channel   dir  handshake     payload
// day_in    in   valid/ready   series_start, day_of_year, temperature, precipitation
// lai_out   out  valid/ready   leaf_area_index, leaf_ratio, season_phase
// apb       in   psel/penable  paddr, pwdata -> prdata, pready tied high
//
// one item per cycle unless lai_out stalls; a result passes the input, product and
// output registers; window and season state update from the input register, so
// that loop sets the rate; the lai scaling multiplies run in two further stages
// reset clears the window fill, the season state and all valid bits at once
// the three stages stall together only where full; ready drops when all are full
// and the output is not taken
`default_nettype none

module leaf_area_season_tracker (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	lst_day_if.sink                          day_in,
	lst_lai_if.source                        lai_out,
	input  wire logic                        psel,
	input  wire logic                        penable,
	input  wire logic                        pwrite,
	input  wire logic [lst_pkg::ADDR_W-1:0]  paddr,
	input  wire logic [lst_pkg::DATA_W-1:0]  pwdata,
	output logic      [lst_pkg::DATA_W-1:0]  prdata,
	output logic                             pready
);
	import lst_pkg::*;

	cfg_t                     cfg;
	win_stat_t                stat;
	logic                     v_s1, v_s2, v_s3;
	logic                     adv1, adv2, adv3;
	logic                     take;
	logic                     ss_s1;
	logic [DOY_W-1:0]         doy_s1;
	logic signed [TEMP_W-1:0] temp_s1;
	logic [PREC_W-1:0]        prec_s1;
	logic [RATIO_W-1:0]       ratio;
	phase_t                   phase;
	phase_t                   phase_out;

	assign adv3 = !v_s3 || lai_out.ready;
	assign adv2 = !v_s2 || adv3;
	assign adv1 = !v_s1 || adv2;
	assign take = v_s1 && adv2;

	assign day_in.ready  = adv1;
	assign lai_out.valid = v_s3;
	assign lai_out.season_phase = phase_out;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (adv1) v_s1 <= day_in.valid;
			if (adv2) v_s2 <= v_s1;
			if (adv3) v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv1) begin
			ss_s1   <= day_in.series_start;
			doy_s1  <= day_in.day_of_year;
			temp_s1 <= day_in.temperature;
			prec_s1 <= day_in.precipitation;
		end
	end

	lst_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	lst_window u_window (
		.clk          (clk),
		.arst_n       (arst_n),
		.take         (take),
		.series_start (ss_s1),
		.temperature  (temp_s1),
		.window_days  (cfg.window_days),
		.stat         (stat)
	);

	lst_season u_season (
		.clk           (clk),
		.arst_n        (arst_n),
		.take          (take),
		.series_start  (ss_s1),
		.day_of_year   (doy_s1),
		.precipitation (prec_s1),
		.stat          (stat),
		.cfg           (cfg),
		.ratio         (ratio),
		.phase         (phase)
	);

	lst_scale u_scale (
		.clk             (clk),
		.load_s2         (adv2),
		.load_s3         (adv3),
		.ratio           (ratio),
		.phase           (phase),
		.cfg             (cfg),
		.leaf_area_index (lai_out.leaf_area_index),
		.leaf_ratio      (lai_out.leaf_ratio),
		.season_phase    (phase_out)
	);

	a_ratio_range: assert property (@(posedge clk) disable iff (!arst_n)
		lai_out.valid |-> lai_out.leaf_ratio <= RATIO_W'(RAMP_DAYS))
		else $error("leaf ratio above ramp length");

	a_grow_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		lai_out.valid && lai_out.season_phase == PH_GROW |-> lai_out.leaf_ratio != '0)
		else $error("growing phase with zero ratio");

	a_lai_bounds: assert property (@(posedge clk) disable iff (!arst_n)
		lai_out.valid && cfg.lai_max >= cfg.lai_min |->
		lai_out.leaf_area_index >= cfg.lai_min && lai_out.leaf_area_index <= cfg.lai_max)
		else $error("leaf area index outside limits");

	a_accept_fills_s1: assert property (@(posedge clk) disable iff (!arst_n)
		day_in.valid && day_in.ready |=> v_s1)
		else $error("accepted item lost before input stage");

	a_full_stall: assert property (@(posedge clk) disable iff (!arst_n)
		v_s1 && v_s2 && v_s3 && !lai_out.ready |-> !day_in.ready)
		else $error("ready high with full pipeline stalled");

endmodule

`default_nettype wire

@@ dv/tb_leaf_area_season_tracker.sv @@
`default_nettype none

module tb_leaf_area_season_tracker;
	timeunit 1ns;
	timeprecision 1ps;

	import lst_pkg::*;

	localparam int STALL_LIMIT = 5000;
	localparam int MAX_REPORTS = 100;

	typedef struct {
		logic [LAI_W-1:0]   lai;
		logic [RATIO_W-1:0] ratio;
		phase_t             phase;
	} lai_result_t;

	logic clk;
	logic arst_n;
	logic psel;
	logic penable;
	logic pwrite;
	logic [ADDR_W-1:0] paddr;
	logic [DATA_W-1:0] pwdata;
	logic [DATA_W-1:0] prdata;
	logic pready;

	lst_day_if day_if ();
	lst_lai_if lai_if ();

	leaf_area_season_tracker uut (
		.clk     (clk),
		.arst_n  (arst_n),
		.day_in  (day_if),
		.lai_out (lai_if),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	// model copy of configuration and season state
	cfg_t cfg_model;
	int   temp_hist [MAX_WINDOW_DAYS];
	int   hist_fill;
	int   rain_sum;
	int   season_day;
	int   grow_days;
	int   droop_days;
	int   ratio_prev;
	bit   year_on;
	bit   grown;
	bit   drooped;

	lai_result_t lai_expect_q[$];
	lai_result_t lai_head;

	int  mismatch_count;
	int  quiet_cycles;
	int  cal_day;
	bit  src_idle_en;
	bit  snk_stall_en;

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	function automatic void clear_season();
		for (int i = 0; i < MAX_WINDOW_DAYS; i++)
			temp_hist[i] = 0;
		hist_fill  = 0;
		rain_sum   = 0;
		season_day = 0;
		grow_days  = 0;
		droop_days = 0;
		ratio_prev = 0;
		year_on    = 1'b0;
		grown      = 1'b0;
		drooped    = 1'b0;
	endfunction

	function automatic int clip_temp(input int v);
		if (v > 1023)
			return 1023;
		if (v < -1024)
			return -1024;
		return v;
	endfunction

	// works out the leaf area result of one day and queues it
	function automatic void predict_leaf_area(input logic ss, input logic [DOY_W-1:0] doy,
		input int temp, input int prec);
		int look;
		int span;
		int tmin;
		int tmax;
		int thr;
		int ratio;
		int lai;
		int lmin;
		int lmax;
		int first_day;
		bit grow_now;
		bit droop_now;
		lai_result_t r;

		grow_now  = 1'b0;
		droop_now = 1'b0;
		thr  = int'($signed(cfg_model.temp_threshold));
		lmin = int'(cfg_model.lai_min);
		lmax = int'(cfg_model.lai_max);

		if (ss)
			clear_season();

		for (int i = MAX_WINDOW_DAYS - 1; i > 0; i--)
			temp_hist[i] = temp_hist[i-1];
		temp_hist[0] = temp;
		if (hist_fill < MAX_WINDOW_DAYS)
			hist_fill++;

		look = int'(cfg_model.window_days);
		if (look > MAX_WINDOW_DAYS - 1)
			look = MAX_WINDOW_DAYS - 1;
		span = (look + 1 > hist_fill) ? hist_fill : look + 1;
		tmin = temp_hist[0];
		tmax = temp_hist[0];
		for (int i = 1; i < span; i++) begin
			if (temp_hist[i] < tmin)
				tmin = temp_hist[i];
			if (temp_hist[i] > tmax)
				tmax = temp_hist[i];
		end

		first_day = cfg_model.southern_hemisphere ? SOUTH_START : NORTH_START;
		if (int'(doy) == first_day) begin
			year_on    = 1'b1;
			season_day = 0;
			rain_sum   = 0;
			grown      = 1'b0;
			drooped    = 1'b0;
			grow_days  = 0;
			droop_days = 0;
		end else if (year_on && season_day < 511) begin
			season_day++;
		end

		if (year_on) begin
			rain_sum += prec;
			if (rain_sum > 65535)
				rain_sum = 65535;
			if (grown && grow_days < RAMP_DAYS)
				grow_days++;
			if (drooped && droop_days < RAMP_DAYS)
				droop_days++;
			if (!drooped && season_day >= DROOP_FROM_DAY && tmax < thr)
				droop_now = 1'b1;
			if (!grown && !drooped && rain_sum > int'(cfg_model.precip_threshold) && tmin > thr)
				grow_now = 1'b1;
			if (droop_now) begin
				drooped    = 1'b1;
				droop_days = 0;
			end
			if (grow_now) begin
				grown     = 1'b1;
				grow_days = 0;
			end
		end

		if (year_on && drooped) begin
			ratio   = RAMP_DAYS - droop_days;
			r.phase = PH_DROOP;
		end else if (year_on && grown) begin
			ratio   = (grow_days + 1 > RAMP_DAYS) ? RAMP_DAYS : grow_days + 1;
			r.phase = PH_GROW;
		end else begin
			ratio   = ratio_prev;
			r.phase = PH_HELD;
		end
		ratio_prev = ratio;

		// reversed limits: scaled difference truncates toward zero
		if (lmax >= lmin)
			lai = lmin + (ratio * (lmax - lmin)) / RAMP_DAYS;
		else
			lai = lmin - (ratio * (lmin - lmax)) / RAMP_DAYS;

		r.lai   = lai[LAI_W-1:0];
		r.ratio = ratio[RATIO_W-1:0];
		lai_expect_q = {lai_expect_q, r};
	endfunction

	task automatic send_day(input logic ss, input logic [DOY_W-1:0] doy, input int temp,
		input int prec);
		while (src_idle_en && $urandom_range(99) < 21) begin
			day_if.valid <= 1'b0;
			@(posedge clk);
		end
		day_if.valid         <= 1'b1;
		day_if.series_start  <= ss;
		day_if.day_of_year   <= doy;
		day_if.temperature   <= temp[TEMP_W-1:0];
		day_if.precipitation <= prec[PREC_W-1:0];
		@(posedge clk);
		while (!day_if.ready)
			@(posedge clk);
		predict_leaf_area(ss, doy, temp, prec);
	endtask

	// stop sending and let every queued result come out
	task automatic wait_drained();
		day_if.valid <= 1'b0;
		while (lai_expect_q.size() != 0)
			@(posedge clk);
		repeat (6) @(posedge clk);
	endtask

	task automatic write_reg(input reg_idx_t idx, input int value);
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= ADDR_W'(4 * int'(idx));
		pwdata  <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		case (idx)
			REG_LAI_MIN:     cfg_model.lai_min             = value[LAI_W-1:0];
			REG_LAI_MAX:     cfg_model.lai_max             = value[LAI_W-1:0];
			REG_WINDOW_DAYS: cfg_model.window_days         = value[LOOK_W-1:0];
			REG_SOUTHERN:    cfg_model.southern_hemisphere = value[0];
			REG_PRECIP_THR:  cfg_model.precip_threshold    = value[PSUM_W-1:0];
			REG_TEMP_THR:    cfg_model.temp_threshold      = value[TEMP_W-1:0];
			default: ;
		endcase
	endtask

	task automatic write_config(input int lmin, input int lmax, input int win, input int south,
		input int pthr, input int tthr);
		wait_drained();
		write_reg(REG_LAI_MIN, lmin);
		write_reg(REG_LAI_MAX, lmax);
		write_reg(REG_WINDOW_DAYS, win);
		write_reg(REG_SOUTHERN, south);
		write_reg(REG_PRECIP_THR, pthr);
		write_reg(REG_TEMP_THR, tthr);
	endtask

	// a calendar of days with a warm middle of the year and a cold rest
	task automatic run_season(input int n_days, input bit restart);
		int off;
		int temp;
		int prec;
		int thr;
		int first_day;
		logic ss;
		logic [DOY_W-1:0] doy;

		thr       = int'($signed(cfg_model.temp_threshold));
		first_day = cfg_model.southern_hemisphere ? SOUTH_START : NORTH_START;
		if (restart)
			cal_day = $urandom_range(365, 1);
		for (int i = 0; i < n_days; i++) begin
			ss  = (restart && i == 0) || ($urandom_range(999) < 3);
			off = (cal_day - first_day + 365) % 365;
			if (off >= 60 && off < 250)
				temp = thr + int'($urandom_range(350, 20));
			else
				temp = thr - int'($urandom_range(350, 1));
			if ($urandom_range(99) < 2)
				temp = int'($urandom_range(2047)) - 1024;
			prec = ($urandom_range(99) < 5) ? $urandom_range(4095) : $urandom_range(60);
			doy  = DOY_W'(cal_day);
			if ($urandom_range(99) < 1)
				doy = $urandom_range(1) ? '0 : DOY_W'($urandom_range(511, 367));
			send_day(ss, doy, clip_temp(temp), prec);
			if (cal_day >= 366 || (cal_day == 365 && $urandom_range(3) != 0))
				cal_day = 1;
			else
				cal_day++;
		end
	endtask

	task automatic test_directed();
		// nothing summed before the first year start
		send_day(1'b1, 9'd100, -1024, 4095);
		send_day(1'b0, 9'd0, 1023, 0);
		send_day(1'b0, 9'd511, 0, 2730);
		send_day(1'b0, 9'd366, -1, 1365);
		// year start on a fresh series: short history, growth at once
		send_day(1'b1, 9'd1, 1023, 4095);
		for (int d = 2; d <= 7; d++)
			send_day(1'b0, d[DOY_W-1:0], 1023, 0);
		send_day(1'b0, 9'd8, 129, 0);
		send_day(1'b0, 9'd9, 128, 4095);
		// new year holds the ratio until a trigger
		send_day(1'b0, 9'd1, -1024, 0);
		send_day(1'b0, 9'd2, 500, 0);
		// series start drops the held ratio
		send_day(1'b1, 9'd50, 500, 100);
		send_day(1'b0, 9'd183, 500, 100);
		send_day(1'b0, 9'd1, 1023, 640);
		send_day(1'b0, 9'd2, 1023, 1);
		wait_drained();
	endtask

	task automatic test_back_to_back();
		src_idle_en  = 1'b0;
		snk_stall_en = 1'b0;
		run_season(350, 1'b1);
		wait_drained();
		src_idle_en  = 1'b1;
		snk_stall_en = 1'b1;
	endtask

	task automatic test_config_extremes();
		write_config(0, 4095, 0, 0, 0, -1024);
		run_season(250, 1'b1);
		// reversed limits with growth and droop in the southern calendar
		write_config(4095, 0, 31, 1, 1000, 0);
		run_season(400, 1'b1);
		write_config(2048, 2048, 5, 0, 65535, 1023);
		run_season(200, 1'b1);
	endtask

	task automatic test_random_config();
		for (int n = 0; n < 3; n++) begin
			write_config($urandom_range(4095), $urandom_range(4095), $urandom_range(31),
				$urandom_range(1), $urandom_range(3000), int'($urandom_range(300)) - 150);
			run_season(250, 1'b1);
		end
	endtask

	task automatic test_noise();
		int first_day;
		logic [DOY_W-1:0] doy;

		write_config($urandom_range(4095), $urandom_range(4095), $urandom_range(31),
			$urandom_range(1), $urandom_range(65535), int'($urandom_range(2047)) - 1024);
		first_day = cfg_model.southern_hemisphere ? SOUTH_START : NORTH_START;
		for (int i = 0; i < 200; i++) begin
			doy = ($urandom_range(99) < 10) ? first_day[DOY_W-1:0]
				: DOY_W'($urandom_range(511));
			send_day($urandom_range(19) == 0, doy, int'($urandom_range(2047)) - 1024,
				$urandom_range(4095));
		end
	endtask

	always @(posedge clk)
		lai_if.ready <= !snk_stall_en || ($urandom_range(99) >= 21);

	always @(posedge clk) begin
		if (arst_n && lai_if.valid && lai_if.ready) begin
			if (lai_expect_q.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= MAX_REPORTS)
					$display("%0t: result with none expected: lai %0d ratio %0d phase %0d",
						$time, lai_if.leaf_area_index, lai_if.leaf_ratio,
						lai_if.season_phase);
			end else begin
				lai_head = lai_expect_q.pop_front();
				if (lai_if.leaf_area_index !== lai_head.lai) begin
					mismatch_count++;
					if (mismatch_count <= MAX_REPORTS)
						$display("%0t: leaf_area_index expected %0d actual %0d", $time,
							lai_head.lai, lai_if.leaf_area_index);
				end
				if (lai_if.leaf_ratio !== lai_head.ratio) begin
					mismatch_count++;
					if (mismatch_count <= MAX_REPORTS)
						$display("%0t: leaf_ratio expected %0d actual %0d", $time,
							lai_head.ratio, lai_if.leaf_ratio);
				end
				if (lai_if.season_phase !== lai_head.phase) begin
					mismatch_count++;
					if (mismatch_count <= MAX_REPORTS)
						$display("%0t: season_phase expected %0d actual %0d", $time,
							lai_head.phase, lai_if.season_phase);
				end
			end
		end
	end

	// watchdog on cycles with no transfer on any port
	always @(posedge clk) begin
		if ((day_if.valid && day_if.ready) || (lai_if.valid && lai_if.ready) || psel)
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles == STALL_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	initial begin
		arst_n               = 1'b0;
		psel                 = 1'b0;
		penable              = 1'b0;
		pwrite               = 1'b0;
		paddr                = '0;
		pwdata               = '0;
		day_if.valid         = 1'b0;
		day_if.series_start  = 1'b0;
		day_if.day_of_year   = '0;
		day_if.temperature   = '0;
		day_if.precipitation = '0;
		lai_if.ready         = 1'b0;
		mismatch_count       = 0;
		quiet_cycles         = 0;
		cal_day              = 1;
		src_idle_en          = 1'b1;
		snk_stall_en         = 1'b1;
		cfg_model = '{lai_min: LAI_MIN_RST, lai_max: LAI_MAX_RST, window_days: WINDOW_DAYS_RST,
			southern_hemisphere: 1'b0, precip_threshold: PRECIP_THR_RST,
			temp_threshold: TEMP_THR_RST};
		clear_season();

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_back_to_back();
		test_config_extremes();
		test_random_config();
		test_noise();

		wait_drained();
		repeat (10) @(posedge clk);
		if (mismatch_count == 0 && lai_expect_q.size() == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule

`default_nettype wire

@@ filelist.f @@
src/lst_pkg.sv
src/lst_if.sv
src/lst_cfg.sv
src/lst_window.sv
src/lst_season.sv
src/lst_scale.sv
src/leaf_area_season_tracker.sv
dv/tb_leaf_area_season_tracker.sv
